### sv/bchd_pkg.sv
package bchd_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned ThreshW = 16;
  localparam int unsigned PhaseW = 3;
  localparam int unsigned KindW  = 2;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [PhaseW-1:0] PH_IDLE        = 3'd0;
  localparam logic [PhaseW-1:0] PH_DEBOUNCE    = 3'd1;
  localparam logic [PhaseW-1:0] PH_PRESSED     = 3'd2;
  localparam logic [PhaseW-1:0] PH_WAIT_DOUBLE = 3'd3;
  localparam logic [PhaseW-1:0] PH_DEBOUNCE2   = 3'd4;
  localparam logic [PhaseW-1:0] PH_HOLDING     = 3'd5;
  localparam logic [PhaseW-1:0] PH_LATCHED     = 3'd6;

  localparam logic [KindW-1:0] EV_CLICK   = 2'd0;
  localparam logic [KindW-1:0] EV_DOUBLE  = 2'd1;
  localparam logic [KindW-1:0] EV_HOLD    = 2'd2;
  localparam logic [KindW-1:0] EV_RELEASE = 2'd3;

  localparam logic [CfgIdxW-1:0] REG_LATCHING_MODE       = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE_TIME       = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_HOLD_THRESHOLD      = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DOUBLE_CLICK_WINDOW = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_HOLD_REPEAT_PERIOD  = 3'd4;

  localparam logic [ThreshW-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [ThreshW-1:0] HOLD_RST     = 16'd800;
  localparam logic [ThreshW-1:0] DOUBLE_RST   = 16'd300;
  localparam logic [ThreshW-1:0] REPEAT_RST   = 16'd200;

  typedef struct packed {
    logic               latching_mode;
    logic [ThreshW-1:0] debounce_time;
    logic [ThreshW-1:0] hold_threshold;
    logic [ThreshW-1:0] double_click_window;
    logic [ThreshW-1:0] hold_repeat_period;
  } bchd_cfg_t;

  typedef struct packed {
    logic             valid;
    logic [KindW-1:0] kind;
  } bchd_event_t;

  function automatic logic elapsed(input logic [TimeW-1:0] now,
                                   input logic [TimeW-1:0] since,
                                   input logic [ThreshW-1:0] limit);
    logic [TimeW-1:0] diff;
    diff = now - since;
    return diff >= {{(TimeW-ThreshW){1'b0}}, limit};
  endfunction

endpackage

### sv/button_click_hold_detector.sv
// Button click / hold detector. Each input transaction is one poll of the
// button (pressed level and a wrapping millisecond timestamp) and yields zero
// or one event: click, double click, hold start or repeat, release after hold.
// One poll is accepted every cycle while in_stall is low. The result passes
// through the input register, loaded at the accepting edge, and then the event
// register, with the phase machine and its stamp compares in between. A stall
// while the event register holds a result holds both registers, and once the
// input register is also full it raises in_stall in the same cycle.
// Configuration registers take effect at once and must be written only with
// no poll in flight.
module button_click_hold_detector
  import bchd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_button_down,
  input  logic [TimeW-1:0]   in_time_now,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [KindW-1:0]   out_event_kind,
  input  logic               cfg_wr_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ThreshW-1:0] cfg_wdata
);

  bchd_cfg_t   cfg;
  bchd_event_t ev;

  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_down_r;
  logic [TimeW-1:0] s1_now_r;
  logic             out_valid_r, out_valid_nxt;
  logic [KindW-1:0] out_kind_r;
  logic             step;
  logic             in_take;

  bchd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  bchd_fsm u_fsm (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step    (step),
    .in_down (s1_down_r),
    .in_now  (s1_now_r),
    .ev      (ev)
  );

  assign step     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !step;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = in_take ? 1'b1 : (step ? 1'b0 : s1_valid_r);
    if (step) begin
      out_valid_nxt = ev.valid;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_down_r <= in_button_down;
      s1_now_r  <= in_time_now;
    end
    if (step && ev.valid) begin
      out_kind_r <= ev.kind;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = out_kind_r;

endmodule

### sv/bchd_cfg.sv
module bchd_cfg
  import bchd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ThreshW-1:0] cfg_wdata,
  output bchd_cfg_t          cfg
);

  bchd_cfg_t cfg_r;
  bchd_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_LATCHING_MODE:       cfg_nxt.latching_mode       = cfg_wdata[0];
        REG_DEBOUNCE_TIME:       cfg_nxt.debounce_time       = cfg_wdata;
        REG_HOLD_THRESHOLD:      cfg_nxt.hold_threshold      = cfg_wdata;
        REG_DOUBLE_CLICK_WINDOW: cfg_nxt.double_click_window = cfg_wdata;
        REG_HOLD_REPEAT_PERIOD:  cfg_nxt.hold_repeat_period  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.latching_mode       <= 1'b0;
      cfg_r.debounce_time       <= DEBOUNCE_RST;
      cfg_r.hold_threshold      <= HOLD_RST;
      cfg_r.double_click_window <= DOUBLE_RST;
      cfg_r.hold_repeat_period  <= REPEAT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### sv/bchd_fsm.sv
module bchd_fsm
  import bchd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  bchd_cfg_t        cfg,
  input  logic             step,
  input  logic             in_down,
  input  logic [TimeW-1:0] in_now,
  output bchd_event_t      ev
);

  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [TimeW-1:0]  press_start_r, press_start_nxt;
  logic [TimeW-1:0]  last_down_r, last_down_nxt;
  logic [TimeW-1:0]  last_hold_r, last_hold_nxt;
  logic [TimeW-1:0]  release_r, release_nxt;
  logic              hit;
  logic [KindW-1:0]  kind;

  always_comb begin
    phase_nxt       = phase_r;
    press_start_nxt = press_start_r;
    last_down_nxt   = in_down ? in_now : last_down_r;
    last_hold_nxt   = last_hold_r;
    release_nxt     = release_r;
    hit             = 1'b0;
    kind            = EV_CLICK;
    if (cfg.latching_mode) begin
      unique case (phase_r)
        PH_IDLE: begin
          if (in_down) begin
            phase_nxt       = PH_DEBOUNCE;
            press_start_nxt = in_now;
          end
        end
        PH_DEBOUNCE: begin
          if (elapsed(in_now, press_start_r, cfg.debounce_time)) begin
            if (in_down) begin
              phase_nxt = PH_LATCHED;
              hit       = 1'b1;
            end else begin
              phase_nxt = PH_IDLE;
            end
          end
        end
        PH_LATCHED: begin
          if (!in_down && elapsed(in_now, last_down_nxt, cfg.debounce_time)) begin
            phase_nxt = PH_IDLE;
            hit       = 1'b1;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end else begin
      unique case (phase_r)
        PH_IDLE: begin
          if (in_down) begin
            phase_nxt       = PH_DEBOUNCE;
            press_start_nxt = in_now;
          end
        end
        PH_DEBOUNCE: begin
          if (elapsed(in_now, press_start_r, cfg.debounce_time)) begin
            phase_nxt = in_down ? PH_PRESSED : PH_IDLE;
          end
        end
        PH_PRESSED: begin
          if (elapsed(in_now, last_down_nxt, cfg.debounce_time)) begin
            phase_nxt   = PH_WAIT_DOUBLE;
            release_nxt = in_now;
          end else if (elapsed(in_now, press_start_r, cfg.hold_threshold)) begin
            phase_nxt     = PH_HOLDING;
            last_hold_nxt = in_now;
            hit           = 1'b1;
            kind          = EV_HOLD;
          end
        end
        PH_WAIT_DOUBLE: begin
          if (in_down) begin
            phase_nxt       = PH_DEBOUNCE2;
            press_start_nxt = in_now;
          end else if (elapsed(in_now, release_r, cfg.double_click_window)) begin
            phase_nxt = PH_IDLE;
            hit       = 1'b1;
          end
        end
        PH_DEBOUNCE2: begin
          if (elapsed(in_now, press_start_r, cfg.debounce_time)) begin
            if (in_down) begin
              phase_nxt = PH_IDLE;
              hit       = 1'b1;
              kind      = EV_DOUBLE;
            end else begin
              phase_nxt = PH_WAIT_DOUBLE;
            end
          end
        end
        PH_HOLDING: begin
          if (elapsed(in_now, last_down_nxt, cfg.debounce_time)) begin
            phase_nxt = PH_IDLE;
            hit       = 1'b1;
            kind      = EV_RELEASE;
          end else if (elapsed(in_now, last_hold_r, cfg.hold_repeat_period)) begin
            last_hold_nxt = in_now;
            hit           = 1'b1;
            kind          = EV_HOLD;
          end
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      press_start_r <= '0;
      last_down_r   <= '0;
      last_hold_r   <= '0;
      release_r     <= '0;
    end else if (step) begin
      phase_r       <= phase_nxt;
      press_start_r <= press_start_nxt;
      last_down_r   <= last_down_nxt;
      last_hold_r   <= last_hold_nxt;
      release_r     <= release_nxt;
    end
  end

  assign ev.valid = step && hit;
  assign ev.kind  = kind;

  a_latch_phases: assert property (@(posedge clk) disable iff (!rst_n)
    step && cfg.latching_mode |=>
      (phase_r == PH_IDLE || phase_r == PH_DEBOUNCE || phase_r == PH_LATCHED))
    else $error("latching mode left its phase set");

  a_down_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    step && in_down |=> last_down_r == $past(in_now))
    else $error("down stamp not captured");

  a_release_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ev.valid && ev.kind == EV_RELEASE |=> phase_r == PH_IDLE)
    else $error("release did not return to idle");

  a_double_src: assert property (@(posedge clk) disable iff (!rst_n)
    ev.valid && ev.kind == EV_DOUBLE |-> phase_r == PH_DEBOUNCE2 && in_down)
    else $error("double click from wrong phase");

  a_hold_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    ev.valid && ev.kind == EV_HOLD |=> last_hold_r == $past(in_now))
    else $error("hold stamp not captured");

endmodule

### test/tb_button_click_hold_detector.sv
`timescale 1ns / 1ps

module tb_button_click_hold_detector;
  import bchd_pkg::*;

  localparam int unsigned STUCK_LIMIT     = 2000;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_LIMIT     = 1000;
  localparam int unsigned REG_COUNT       = 5;

  typedef struct packed {
    logic             down;
    logic [TimeW-1:0] ms;
  } poll_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_button_down = 1'b0;
  logic [TimeW-1:0]   in_time_now = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [KindW-1:0]   out_event_kind;
  logic               cfg_wr_en = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [ThreshW-1:0] cfg_wdata = '0;

  poll_t            poll_q[$];
  logic [KindW-1:0] pending_events[$];

  logic        in_taken = 1'b0;
  int unsigned stuck_cycles = 0;
  int unsigned error_count = 0;
  int unsigned polls_made = 0;
  bit          quiet = 1'b0;
  bit          hold_off_go = 1'b0;
  bit          hold_off_done = 1'b0;
  int unsigned hold_left = 0;

  logic [TimeW-1:0] clock_ms = '0;
  int unsigned      set_deb, set_hold, set_dbl, set_rep;

  bchd_cfg_t        cfg_shadow;
  logic [PhaseW-1:0] btn_phase;
  logic [TimeW-1:0] press_ms, last_down_ms, last_hold_ms, release_ms;

  button_click_hold_detector dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_button_down (in_button_down),
    .in_time_now    (in_time_now),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_event_kind (out_event_kind),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit ms_passed(input logic [TimeW-1:0] now, input logic [TimeW-1:0] since,
                                   input logic [ThreshW-1:0] lim);
    logic [TimeW-1:0] gap;
    gap = now - since;
    return gap >= {{(TimeW-ThreshW){1'b0}}, lim};
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic predict_poll(input logic down, input logic [TimeW-1:0] now);
    bit               fire;
    logic [KindW-1:0] kind;
    fire = 1'b0;
    kind = EV_CLICK;
    if (down) last_down_ms = now;
    if (cfg_shadow.latching_mode) begin
      case (btn_phase)
        PH_IDLE: if (down) begin
          btn_phase = PH_DEBOUNCE;
          press_ms = now;
        end
        PH_DEBOUNCE: if (ms_passed(now, press_ms, cfg_shadow.debounce_time)) begin
          if (down) begin
            btn_phase = PH_LATCHED;
            fire = 1'b1;
          end else begin
            btn_phase = PH_IDLE;
          end
        end
        PH_LATCHED: if (!down && ms_passed(now, last_down_ms, cfg_shadow.debounce_time)) begin
          btn_phase = PH_IDLE;
          fire = 1'b1;
        end
        default: btn_phase = PH_IDLE;
      endcase
    end else begin
      case (btn_phase)
        PH_IDLE: if (down) begin
          btn_phase = PH_DEBOUNCE;
          press_ms = now;
        end
        PH_DEBOUNCE: if (ms_passed(now, press_ms, cfg_shadow.debounce_time)) begin
          btn_phase = down ? PH_PRESSED : PH_IDLE;
        end
        PH_PRESSED: if (ms_passed(now, last_down_ms, cfg_shadow.debounce_time)) begin
          btn_phase = PH_WAIT_DOUBLE;
          release_ms = now;
        end else if (ms_passed(now, press_ms, cfg_shadow.hold_threshold)) begin
          btn_phase = PH_HOLDING;
          last_hold_ms = now;
          fire = 1'b1;
          kind = EV_HOLD;
        end
        PH_WAIT_DOUBLE: if (down) begin
          btn_phase = PH_DEBOUNCE2;
          press_ms = now;
        end else if (ms_passed(now, release_ms, cfg_shadow.double_click_window)) begin
          btn_phase = PH_IDLE;
          fire = 1'b1;
        end
        PH_DEBOUNCE2: if (ms_passed(now, press_ms, cfg_shadow.debounce_time)) begin
          if (down) begin
            btn_phase = PH_IDLE;
            fire = 1'b1;
            kind = EV_DOUBLE;
          end else begin
            btn_phase = PH_WAIT_DOUBLE;
          end
        end
        PH_HOLDING: if (ms_passed(now, last_down_ms, cfg_shadow.debounce_time)) begin
          btn_phase = PH_IDLE;
          fire = 1'b1;
          kind = EV_RELEASE;
        end else if (ms_passed(now, last_hold_ms, cfg_shadow.hold_repeat_period)) begin
          last_hold_ms = now;
          fire = 1'b1;
          kind = EV_HOLD;
        end
        default: btn_phase = PH_IDLE;
      endcase
    end
    if (fire) pending_events.push_back(kind);
  endtask

  always @(posedge clk) begin
    logic [KindW-1:0] want_kind;
    if (!rst_n) begin
      cfg_shadow.latching_mode = 1'b0;
      cfg_shadow.debounce_time = DEBOUNCE_RST;
      cfg_shadow.hold_threshold = HOLD_RST;
      cfg_shadow.double_click_window = DOUBLE_RST;
      cfg_shadow.hold_repeat_period = REPEAT_RST;
      btn_phase = PH_IDLE;
      press_ms = '0;
      last_down_ms = '0;
      last_hold_ms = '0;
      release_ms = '0;
      in_taken <= 1'b0;
      stuck_cycles <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_LATCHING_MODE:       cfg_shadow.latching_mode = cfg_wdata[0];
          REG_DEBOUNCE_TIME:       cfg_shadow.debounce_time = cfg_wdata;
          REG_HOLD_THRESHOLD:      cfg_shadow.hold_threshold = cfg_wdata;
          REG_DOUBLE_CLICK_WINDOW: cfg_shadow.double_click_window = cfg_wdata;
          REG_HOLD_REPEAT_PERIOD:  cfg_shadow.hold_repeat_period = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("unexpected event kind %0d", out_event_kind));
        end else begin
          want_kind = pending_events.pop_front();
          if (out_event_kind !== want_kind)
            report_mismatch($sformatf("event kind %0d, expected %0d", out_event_kind, want_kind));
        end
      end
      if (in_valid && !in_stall) predict_poll(in_button_down, in_time_now);
      in_taken <= in_valid && !in_stall;
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cycles <= 0;
      else stuck_cycles <= stuck_cycles + 1;
    end
  end

  always @(negedge clk) begin
    poll_t nxt;
    if (rst_n && (!in_valid || in_taken)) begin
      if (poll_q.size() != 0 && (quiet || $urandom_range(99) >= 35)) begin
        nxt = poll_q.pop_front();
        in_valid <= 1'b1;
        in_button_down <= nxt.down;
        in_time_now <= nxt.ms;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (hold_off_go && !hold_off_done) begin
      out_stall <= 1'b1;
      hold_left = HOLD_OFF_CYCLES - 1;
      hold_off_done = 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 35);
    end
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("timeout: %0d cycles without a transaction", STUCK_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic add_poll(input logic down, input logic [TimeW-1:0] ms);
    poll_q.push_back(poll_t'{down, ms});
    polls_made++;
  endtask

  task automatic settle();
    while (poll_q.size() != 0 || in_valid || pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ThreshW-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic configure(input logic mode, input int unsigned deb, input int unsigned hold,
                           input int unsigned dbl, input int unsigned rep);
    set_deb = deb;
    set_hold = hold;
    set_dbl = dbl;
    set_rep = rep;
    write_reg(REG_LATCHING_MODE, {15'($urandom), mode});
    write_reg(REG_DEBOUNCE_TIME, ThreshW'(deb));
    write_reg(REG_HOLD_THRESHOLD, ThreshW'(hold));
    write_reg(REG_DOUBLE_CLICK_WINDOW, ThreshW'(dbl));
    write_reg(REG_HOLD_REPEAT_PERIOD, ThreshW'(rep));
    write_reg(CfgIdxW'(REG_COUNT + $urandom_range(2)), ThreshW'($urandom));
  endtask

  task automatic emit_level(input logic level, input int unsigned span, input int unsigned tick);
    logic [TimeW-1:0] t_start;
    int unsigned      stride;
    t_start = clock_ms;
    stride = (span / 16 > tick) ? span / 16 : tick;
    do begin
      add_poll(level ^ ($urandom_range(19) == 0), clock_ms);
      clock_ms += $urandom_range(stride / 2, stride + stride / 2);
    end while (clock_ms - t_start < span);
  endtask

  task automatic random_polls(input int unsigned count, input int unsigned tick);
    int unsigned goal, span;
    goal = polls_made + count;
    while (polls_made < goal) begin
      if ($urandom_range(99) < 80) begin
        case ($urandom_range(2))
          0: span = $urandom_range(0, set_deb + 1);
          1: span = $urandom_range(set_deb, set_deb + set_hold + 1);
          default: span = $urandom_range(set_hold, set_hold + 4 * set_rep + set_deb + 1);
        endcase
        emit_level(1'b1, span, tick);
        if ($urandom_range(1)) span = $urandom_range(0, set_dbl + set_deb);
        else span = $urandom_range(set_dbl, 2 * set_dbl + 2 * set_deb + 1);
        emit_level(1'b0, span, tick);
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(3) == 0) clock_ms += $urandom;
          else clock_ms += $urandom_range(0, 2 * tick);
          add_poll($urandom_range(1), clock_ms);
        end
      end
    end
  endtask

  initial begin
    int unsigned drain_wait;
    repeat (9) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // click, double click, wrapping click, hold with repeat and release
    add_poll(1'b1, 32'd20000);
    add_poll(1'b1, 32'd20050);
    add_poll(1'b0, 32'd20100);
    add_poll(1'b0, 32'd20400);
    add_poll(1'b1, 32'd30000);
    add_poll(1'b1, 32'd30050);
    add_poll(1'b0, 32'd30100);
    add_poll(1'b1, 32'd30200);
    add_poll(1'b1, 32'd30250);
    add_poll(1'b1, 32'hFFFF_FFFF);
    add_poll(1'b1, 32'h0000_0031);
    add_poll(1'b0, 32'h0000_0070);
    add_poll(1'b0, 32'h0000_0200);
    add_poll(1'b1, 32'd0);
    add_poll(1'b1, 32'd50);
    add_poll(1'b1, 32'd800);
    add_poll(1'b1, 32'd1000);
    add_poll(1'b0, 32'd1100);
    settle();

    // latching press and release, then leave it latched and drop to momentary
    configure(1'b1, DEBOUNCE_RST, HOLD_RST, DOUBLE_RST, REPEAT_RST);
    add_poll(1'b1, 32'd5000);
    add_poll(1'b1, 32'd5060);
    add_poll(1'b0, 32'd5200);
    add_poll(1'b1, 32'd5300);
    add_poll(1'b1, 32'd5400);
    settle();
    write_reg(REG_LATCHING_MODE, '0);
    add_poll(1'b0, 32'd5500);
    settle();

    configure(1'b0, 50, 800, 300, 200);
    clock_ms = $urandom;
    hold_off_go = 1'b1;
    random_polls(200, 15);
    settle();

    configure(1'b1, 30, 800, 300, 200);
    clock_ms = $urandom;
    random_polls(190, 10);
    settle();

    configure(1'b0, 0, 0, 0, 0);
    clock_ms = $urandom;
    random_polls(180, 3);
    settle();

    configure(1'b0, 65535, 65535, 65535, 65535);
    clock_ms = 32'hFFF0_0000;
    random_polls(190, 6000);
    settle();

    configure(1'b1, 0, $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535));
    clock_ms = $urandom;
    quiet = 1'b1;
    random_polls(190, 4);
    settle();
    quiet = 1'b0;

    configure(1'b0, $urandom_range(1, 100), $urandom_range(100, 1500),
              $urandom_range(50, 600), $urandom_range(1, 300));
    clock_ms = $urandom;
    random_polls(200, 1 + set_deb / 4);
    settle();

    configure(1'b1, 65535, $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 65535));
    clock_ms = $urandom;
    random_polls(150, 6000);

    while (poll_q.size() != 0 || in_valid) @(posedge clk);
    drain_wait = 0;
    while (pending_events.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_events.size() != 0)
      report_mismatch($sformatf("%0d expected events never arrived", pending_events.size()));
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
